// ----- rtl/bqe_pkg.sv -----
//------------------------------------------------------------------------------
// bqe_pkg
// Shared widths, register indexes, reset values, lane handshake structs and
// the state encodings of the quote engine.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package bqe_pkg;

	localparam int FRAC_W    = 16;            // belief, Q0.16
	localparam int PRICE_W   = 24;            // prices in ticks
	localparam int MODE_W    = 2;
	localparam int WT_W      = FRAC_W + 1;    // weights S, W and complement Q
	localparam int PROD_W    = 2 * WT_W;      // weight * belief products, sums
	localparam int CFG_IDX_W = 3;
	localparam int CNT_W     = $clog2(PRICE_W);

	localparam logic [WT_W-1:0]       ONE_WT       = WT_W'(1) << FRAC_W;
	localparam logic [PROD_W-1:0]     DEN_TOTAL    = PROD_W'(1) << (2 * FRAC_W + 1);
	localparam logic [PRICE_W-1:0]    BELIEF_SCALE = PRICE_W'(1) << FRAC_W;
	localparam logic [FRAC_W-1:0]     BELIEF_MAX   = '1;
	localparam logic [2*FRAC_W-1:0]   DRIFT_RND    = (2 * FRAC_W)'(1) << (FRAC_W - 1);

	localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BUY  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SELL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_INFORMED_SHARE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_HIGH      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_LOW       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSION_GAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_RUN_BELIEF = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BELIEF_FLOOR    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BELIEF_CEILING  = 3'd6;

	localparam logic [FRAC_W-1:0]  RST_INFORMED_SHARE  = 16'd55705;
	localparam logic [PRICE_W-1:0] RST_VALUE_HIGH      = 24'd12000;
	localparam logic [PRICE_W-1:0] RST_VALUE_LOW       = 24'd8000;
	localparam logic [FRAC_W-1:0]  RST_REVERSION_GAIN  = 16'd66;
	localparam logic [FRAC_W-1:0]  RST_LONG_RUN_BELIEF = 16'd32768;
	localparam logic [FRAC_W-1:0]  RST_BELIEF_FLOOR    = 16'd3277;
	localparam logic [FRAC_W-1:0]  RST_BELIEF_CEILING  = 16'd62259;
	localparam logic [FRAC_W-1:0]  RST_BELIEF          = 16'd32768;
	// quotes at belief one half with the reset register values
	localparam logic [PRICE_W-1:0] RST_ASK             = 24'd11700;
	localparam logic [PRICE_W-1:0] RST_BID             = 24'd8300;

	typedef struct packed {
		logic               start;
		logic [PROD_W-1:0]  x;
		logic [PROD_W-1:0]  den;
		logic [PRICE_W-1:0] m;
	} lane_req_t;

	typedef struct packed {
		logic               done;
		logic               den_zero;
		logic [PRICE_W-1:0] quot;
	} lane_rsp_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_MUL,
		SQ_LAUNCH,
		SQ_BEL,
		SQ_QUO,
		SQ_DRIFT,
		SQ_CLAMP,
		SQ_SEND
	} seq_state_t;

	typedef enum logic [1:0] {
		LN_IDLE,
		LN_RUN,
		LN_FIX
	} lane_state_t;

endpackage

// ----- rtl/bqe_if.sv -----
//------------------------------------------------------------------------------
// bqe_if
// Valid/ready channels of the quote engine: step requests in, results out.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bqe_step_if;
	import bqe_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic              refresh_quotes;

	modport source (output valid, output mode, output refresh_quotes, input ready);
	modport sink   (input valid, input mode, input refresh_quotes, output ready);
endinterface

interface bqe_result_if;
	import bqe_pkg::*;

	logic               valid;
	logic               ready;
	logic [PRICE_W-1:0] bid_quote;
	logic [PRICE_W-1:0] ask_quote;
	logic [FRAC_W-1:0]  belief_out;
	logic               quotes_changed;

	modport source (
		output valid, output bid_quote, output ask_quote, output belief_out,
		output quotes_changed, input ready
	);
	modport sink (
		input valid, input bid_quote, input ask_quote, input belief_out,
		input quotes_changed, output ready
	);
endinterface

// ----- rtl/bayesian_quote_engine_top.sv -----
//------------------------------------------------------------------------------
// bayesian_quote_engine_top
// Accepts a new step request only when idle, after the previous result has moved
// into the output register. The rate is set by the bit-serial multiply-divide lanes:
// a digit step per multiplier bit, then a rounding step per division; a trade runs
// the belief division, then ask and bid together.
// Reset (async, active low): belief one half, quotes at that belief; no sweep.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module bayesian_quote_engine_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bqe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bqe_pkg::PRICE_W-1:0]   cfg_data,
	bqe_step_if.sink                      step,
	bqe_result_if.source                  result
);
	import bqe_pkg::*;

	// configuration
	logic [FRAC_W-1:0]  informed_share_q, reversion_gain_q, long_run_q;
	logic [FRAC_W-1:0]  floor_q, ceiling_q;
	logic [PRICE_W-1:0] value_high_q, value_low_q;

	// state
	seq_state_t         state_q, state_d;
	logic [FRAC_W-1:0]  belief_q;
	logic [PRICE_W-1:0] bid_q, ask_q;
	logic               changed_q, buy_q, bel_pend_q;
	logic [PROD_W-1:0]  sp_q, wq_q;
	logic [2*FRAC_W-1:0] drift_prod_q;
	logic               drift_up_q;
	logic               out_valid_q, out_changed_q;
	logic [PRICE_W-1:0] out_bid_q, out_ask_q;
	logic [FRAC_W-1:0]  out_belief_q;

	// control
	logic               step_ready, accept, trade_in, launch, send_ok;
	lane_req_t          req_a, req_b;
	lane_rsp_t          rsp_a, rsp_b;

	// arithmetic
	logic [WT_W-1:0]    s_wt, w_wt, p_wt, q_wt;
	logic [PROD_W-1:0]  sp_prod, wq_prod, wp, sq, den_ask, den_bid;
	logic               hi_ge;
	logic [PRICE_W-1:0] span, lo_val;
	logic [FRAC_W-1:0]  bel_new, dif, step_v, moved, clamped;
	logic               up;
	logic [2*FRAC_W-1:0] drift_prod, rsum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			informed_share_q <= RST_INFORMED_SHARE;
			value_high_q     <= RST_VALUE_HIGH;
			value_low_q      <= RST_VALUE_LOW;
			reversion_gain_q <= RST_REVERSION_GAIN;
			long_run_q       <= RST_LONG_RUN_BELIEF;
			floor_q          <= RST_BELIEF_FLOOR;
			ceiling_q        <= RST_BELIEF_CEILING;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INFORMED_SHARE:  informed_share_q <= cfg_data[FRAC_W-1:0];
				REG_VALUE_HIGH:      value_high_q     <= cfg_data;
				REG_VALUE_LOW:       value_low_q      <= cfg_data;
				REG_REVERSION_GAIN:  reversion_gain_q <= cfg_data[FRAC_W-1:0];
				REG_LONG_RUN_BELIEF: long_run_q       <= cfg_data[FRAC_W-1:0];
				REG_BELIEF_FLOOR:    floor_q          <= cfg_data[FRAC_W-1:0];
				REG_BELIEF_CEILING:  ceiling_q        <= cfg_data[FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	// weights in units of 2^-16: S = 1 + alpha, W = 1 - alpha
	assign s_wt    = {1'b1, informed_share_q};
	assign w_wt    = ONE_WT - {1'b0, informed_share_q};
	assign p_wt    = {1'b0, belief_q};
	assign q_wt    = ONE_WT - {1'b0, belief_q};
	assign sp_prod = s_wt * p_wt;
	assign wq_prod = w_wt * q_wt;

	// S + W = 2^17 and P + Q = 2^16 give the other two products and the bid divisor
	assign wp      = {1'b0, belief_q, {WT_W{1'b0}}} - sp_q;
	assign sq      = {q_wt, {WT_W{1'b0}}} - wq_q;
	assign den_ask = sp_q + wq_q;
	assign den_bid = DEN_TOTAL - den_ask;

	// price = lower value + weight of the higher value * spread / divisor
	assign hi_ge   = value_high_q >= value_low_q;
	assign span    = hi_ge ? (value_high_q - value_low_q) : (value_low_q - value_high_q);
	assign lo_val  = hi_ge ? value_low_q : value_high_q;

	assign bel_new = (rsp_a.quot[PRICE_W-1:FRAC_W] != '0) ? BELIEF_MAX
		: rsp_a.quot[FRAC_W-1:0];

	assign up         = long_run_q >= belief_q;
	assign dif        = up ? (long_run_q - belief_q) : (belief_q - long_run_q);
	assign drift_prod = dif * reversion_gain_q;
	assign rsum       = drift_prod_q + DRIFT_RND;
	assign step_v     = rsum[2*FRAC_W-1:FRAC_W];
	assign moved      = drift_up_q ? (belief_q + step_v) : (belief_q - step_v);

	always_comb begin
		if (moved < floor_q)
			clamped = floor_q;
		else if (moved > ceiling_q)
			clamped = ceiling_q;
		else
			clamped = moved;
	end

	assign trade_in = step.mode inside {MODE_BUY, MODE_SELL};

	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (step.valid) begin
					if (trade_in || step.refresh_quotes)
						state_d = SQ_MUL;
					else
						state_d = SQ_DRIFT;
				end
			end
			SQ_MUL: begin
				state_d = SQ_LAUNCH;
			end
			SQ_LAUNCH: begin
				state_d = bel_pend_q ? SQ_BEL : SQ_QUO;
			end
			SQ_BEL: begin
				// new belief, then products again for the quotes
				if (rsp_a.done) state_d = SQ_MUL;
			end
			SQ_QUO: begin
				if (rsp_a.done) state_d = SQ_DRIFT;
			end
			SQ_DRIFT: begin
				state_d = SQ_CLAMP;
			end
			SQ_CLAMP: begin
				state_d = SQ_SEND;
			end
			SQ_SEND: begin
				if (!out_valid_q || result.ready) state_d = SQ_IDLE;
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	always_comb begin
		step_ready = (state_q == SQ_IDLE);
		launch     = (state_q == SQ_LAUNCH);
		send_ok    = (state_q == SQ_SEND) && (!out_valid_q || result.ready);

		// lane A: belief update, or the ask
		req_a.start = launch;
		if (bel_pend_q) begin
			req_a.x   = buy_q ? sp_q : wp;
			req_a.den = buy_q ? den_ask : den_bid;
			req_a.m   = BELIEF_SCALE;
		end else begin
			req_a.x   = hi_ge ? sp_q : wq_q;
			req_a.den = den_ask;
			req_a.m   = span;
		end

		// lane B: the bid
		req_b.start = launch && !bel_pend_q;
		req_b.x     = hi_ge ? wp : sq;
		req_b.den   = den_bid;
		req_b.m     = span;
	end

	assign accept     = step.valid && step_ready;
	assign step.ready = step_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			changed_q   <= 1'b0;
			buy_q       <= 1'b0;
			bel_pend_q  <= 1'b0;
			belief_q    <= RST_BELIEF;
			bid_q       <= RST_BID;
			ask_q       <= RST_ASK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				changed_q  <= trade_in || step.refresh_quotes;
				buy_q      <= (step.mode == MODE_BUY);
				bel_pend_q <= trade_in;
			end
			if ((state_q == SQ_BEL) && rsp_a.done) begin
				bel_pend_q <= 1'b0;
				if (!rsp_a.den_zero) belief_q <= bel_new;
			end
			if ((state_q == SQ_QUO) && rsp_a.done) begin
				ask_q <= rsp_a.den_zero ? value_high_q : (lo_val + rsp_a.quot);
				bid_q <= rsp_b.den_zero ? value_low_q : (lo_val + rsp_b.quot);
			end
			if (state_q == SQ_CLAMP)
				belief_q <= clamped;
			if (send_ok)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SQ_MUL) begin
			sp_q <= sp_prod;
			wq_q <= wq_prod;
		end
		if (state_q == SQ_DRIFT) begin
			drift_prod_q <= drift_prod;
			drift_up_q   <= up;
		end
		if (send_ok) begin
			out_bid_q     <= bid_q;
			out_ask_q     <= ask_q;
			out_belief_q  <= belief_q;
			out_changed_q <= changed_q;
		end
	end

	bqe_muldiv u_lane_a (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_a),
		.rsp    (rsp_a)
	);

	bqe_muldiv u_lane_b (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_b),
		.rsp    (rsp_b)
	);

	assign result.valid          = out_valid_q;
	assign result.bid_quote      = out_bid_q;
	assign result.ask_quote      = out_ask_q;
	assign result.belief_out     = out_belief_q;
	assign result.quotes_changed = out_changed_q;

	a_lanes_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_QUO) |-> (rsp_a.done == rsp_b.done))
		else $error("quote lanes finished apart");

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_a.done || rsp_b.done) |-> (state_q == SQ_BEL || state_q == SQ_QUO))
		else $error("lane finished outside a wait state");

	a_belief_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == SQ_BEL) && rsp_a.done && !rsp_a.den_zero)
			|-> (rsp_a.quot <= BELIEF_SCALE))
		else $error("belief quotient above one");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> ($past(state_q) == SQ_SEND))
		else $error("result raised outside send state");

endmodule

// ----- rtl/bqe_muldiv.sv -----
//------------------------------------------------------------------------------
// bqe_muldiv
// Bit-serial fused multiply-divide: quot = floor((x * m + floor(den/2)) / den)
// for x <= den. One multiplier bit per cycle, MSB first, then a rounding step.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module bqe_muldiv (
	input  logic                clk,
	input  logic                arst_n,
	input  bqe_pkg::lane_req_t  req,
	output bqe_pkg::lane_rsp_t  rsp
);
	import bqe_pkg::*;

	lane_state_t        state_q, state_d;
	logic [PROD_W-1:0]  x_q, den_q, rem_q;
	logic [PRICE_W-1:0] m_q, quot_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               zero_q, done_q;
	logic               load, run, fix;

	logic [PROD_W:0]    acc, den2, sub1, sub2, round_sum;
	logic               ge1, ge2, round_up;
	logic [1:0]         qdig;

	// Horner step: 2R + bit*x stays below 3*den, so the digit is 0, 1 or 2
	always_comb begin
		acc       = {rem_q, 1'b0} + (m_q[PRICE_W-1] ? {1'b0, x_q} : '0);
		den2      = {den_q, 1'b0};
		sub1      = acc - {1'b0, den_q};
		sub2      = acc - den2;
		ge1       = acc >= {1'b0, den_q};
		ge2       = acc >= den2;
		qdig      = ge2 ? 2'd2 : (ge1 ? 2'd1 : 2'd0);
		round_sum = {1'b0, rem_q} + {2'b0, den_q[PROD_W-1:1]};
		round_up  = round_sum >= {1'b0, den_q};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			LN_IDLE: begin
				if (req.start) state_d = LN_RUN;
			end
			LN_RUN: begin
				if (cnt_q == '0) state_d = LN_FIX;
			end
			LN_FIX: begin
				state_d = LN_IDLE;
			end
			default: begin
				state_d = LN_IDLE;
			end
		endcase
	end

	always_comb begin
		load = (state_q == LN_IDLE) && req.start;
		run  = (state_q == LN_RUN);
		fix  = (state_q == LN_FIX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LN_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= fix;
			if (load)
				cnt_q <= CNT_W'(PRICE_W - 1);
			else if (run)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q    <= req.x;
			den_q  <= req.den;
			m_q    <= req.m;
			rem_q  <= '0;
			quot_q <= '0;
			zero_q <= (req.den == '0);
		end else if (run) begin
			m_q    <= {m_q[PRICE_W-2:0], 1'b0};
			rem_q  <= ge2 ? sub2[PROD_W-1:0] : (ge1 ? sub1[PROD_W-1:0] : acc[PROD_W-1:0]);
			quot_q <= {quot_q[PRICE_W-2:0], 1'b0} + PRICE_W'(qdig);
		end else if (fix) begin
			if (round_up) quot_q <= quot_q + 1'b1;
		end
	end

	always_comb begin
		rsp.done     = done_q;
		rsp.den_zero = zero_q;
		rsp.quot     = quot_q;
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (state_q == LN_IDLE))
		else $error("muldiv: start while busy");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(run && !zero_q) |-> (rem_q < den_q))
		else $error("muldiv: partial remainder not below divisor");

	a_m_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		fix |-> (m_q == '0))
		else $error("muldiv: multiplier bits left at rounding step");

endmodule

// ----- dv/bqe_checker.sv -----
//------------------------------------------------------------------------------
// bqe_checker
// Watches the step and result channels and the register port of the quote
// engine. Keeps its own belief, quotes and register copies, predicts one result
// per accepted step request and compares every returned result field by field.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module bqe_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bqe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bqe_pkg::PRICE_W-1:0]   cfg_data,
	bqe_step_if                           step,
	bqe_result_if                         result,
	output int                            quotes_pending,
	output int                            quote_errors
);
	import bqe_pkg::*;

	localparam longint unsigned UNITY = 64'd1 << FRAC_W;

	typedef struct packed {
		logic [PRICE_W-1:0] bid;
		logic [PRICE_W-1:0] ask;
		logic [FRAC_W-1:0]  belief;
		logic               changed;
	} quote_step_t;

	logic [FRAC_W-1:0]  share_r;
	logic [PRICE_W-1:0] vhigh_r;
	logic [PRICE_W-1:0] vlow_r;
	logic [FRAC_W-1:0]  gain_r;
	logic [FRAC_W-1:0]  mean_r;
	logic [FRAC_W-1:0]  floor_r;
	logic [FRAC_W-1:0]  ceil_r;

	logic [FRAC_W-1:0]  belief_r;
	logic [PRICE_W-1:0] bid_r;
	logic [PRICE_W-1:0] ask_r;

	quote_step_t quotes_due[$];
	int          results_seen;

	// weighted average of the two values, rounded half up
	function automatic logic [PRICE_W-1:0] blend_price(input longint unsigned wp, wq, p,
			vh, vl, fallback);
		longint unsigned q;
		longint unsigned den;
		longint unsigned num;
		q   = UNITY - p;
		den = wp * p + wq * q;
		if (den == 0) begin
			return PRICE_W'(fallback);
		end
		num = wp * p * vh + wq * q * vl;
		return PRICE_W'((num + den / 2) / den);
	endfunction

	function automatic void requote();
		longint unsigned s;
		longint unsigned w;
		s     = UNITY + share_r;
		w     = UNITY - share_r;
		ask_r = blend_price(s, w, belief_r, vhigh_r, vlow_r, vhigh_r);
		bid_r = blend_price(w, s, belief_r, vhigh_r, vlow_r, vlow_r);
	endfunction

	function automatic logic [FRAC_W-1:0] bayes_update(input logic buy);
		longint unsigned p;
		longint unsigned q;
		longint unsigned s;
		longint unsigned w;
		longint unsigned num;
		longint unsigned den;
		longint unsigned r;
		p   = belief_r;
		q   = UNITY - p;
		s   = UNITY + share_r;
		w   = UNITY - share_r;
		num = buy ? s * p : w * p;
		den = num + (buy ? w * q : s * q);
		if (den == 0) begin
			return belief_r;
		end
		r = (num * UNITY + den / 2) / den;
		return (r > UNITY - 1) ? BELIEF_MAX : FRAC_W'(r);
	endfunction

	// pull toward the long-run mean, then clamp; floor test wins
	function automatic logic [FRAC_W-1:0] revert(input logic [FRAC_W-1:0] belief_in);
		longint unsigned p;
		longint unsigned m;
		longint unsigned g;
		p = belief_in;
		m = mean_r;
		g = gain_r;
		if (m >= p) begin
			p = p + (((m - p) * g + UNITY / 2) >> FRAC_W);
		end else begin
			p = p - (((p - m) * g + UNITY / 2) >> FRAC_W);
		end
		if (p < floor_r) begin
			p = floor_r;
		end else if (p > ceil_r) begin
			p = ceil_r;
		end
		return FRAC_W'(p);
	endfunction

	function automatic quote_step_t predict_step(input logic [MODE_W-1:0] mode,
			input logic refresh);
		quote_step_t e;
		logic        moved;
		moved = 1'b0;
		if (refresh) begin
			requote();
			moved = 1'b1;
		end
		if (mode == MODE_BUY || mode == MODE_SELL) begin
			belief_r = bayes_update(mode == MODE_BUY);
			requote();
			moved = 1'b1;
		end
		belief_r  = revert(belief_r);
		e.bid     = bid_r;
		e.ask     = ask_r;
		e.belief  = belief_r;
		e.changed = moved;
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		quote_step_t want;
		if (!arst_n) begin
			share_r  = RST_INFORMED_SHARE;
			vhigh_r  = RST_VALUE_HIGH;
			vlow_r   = RST_VALUE_LOW;
			gain_r   = RST_REVERSION_GAIN;
			mean_r   = RST_LONG_RUN_BELIEF;
			floor_r  = RST_BELIEF_FLOOR;
			ceil_r   = RST_BELIEF_CEILING;
			belief_r = RST_BELIEF;
			requote();
			quotes_due.delete();
			results_seen   = 0;
			quote_errors   = 0;
			quotes_pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_INFORMED_SHARE:  share_r = cfg_data[FRAC_W-1:0];
					REG_VALUE_HIGH:      vhigh_r = cfg_data;
					REG_VALUE_LOW:       vlow_r  = cfg_data;
					REG_REVERSION_GAIN:  gain_r  = cfg_data[FRAC_W-1:0];
					REG_LONG_RUN_BELIEF: mean_r  = cfg_data[FRAC_W-1:0];
					REG_BELIEF_FLOOR:    floor_r = cfg_data[FRAC_W-1:0];
					REG_BELIEF_CEILING:  ceil_r  = cfg_data[FRAC_W-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				results_seen++;
				if (quotes_due.size() == 0) begin
					quote_errors++;
					if (quote_errors <= 10) begin
						$display("result %0d with no step request pending: %s %0d %0d %0d",
							results_seen, "bid/ask/belief", result.bid_quote,
							result.ask_quote, result.belief_out);
					end
				end else begin
					want = quotes_due.pop_front();
					if (result.bid_quote !== want.bid || result.ask_quote !== want.ask ||
							result.belief_out !== want.belief ||
							result.quotes_changed !== want.changed) begin
						quote_errors++;
						if (quote_errors <= 10) begin
							$display("result %0d wrong (exp/got): bid %0d/%0d ask %0d/%0d",
								results_seen, want.bid, result.bid_quote,
								want.ask, result.ask_quote);
							$display("  belief %0d/%0d changed %0b/%0b",
								want.belief, result.belief_out,
								want.changed, result.quotes_changed);
						end
					end
				end
			end
			if (step.valid && step.ready) begin
				quotes_due.push_back(predict_step(step.mode, step.refresh_quotes));
			end
			quotes_pending = quotes_due.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
//------------------------------------------------------------------------------
// tb_top
// Drives step requests and register writes into the quote engine under random
// idling on both channels, with a long output back-pressure stretch and full
// drains between register settings. The checker instance predicts and compares.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import bqe_pkg::*;

	localparam int RESET_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 64;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 230;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PRICE_W-1:0]   cfg_data;

	int quotes_pending;
	int quote_errors;
	int idle_cycles = 0;
	bit calm = 1'b0;
	bit rx_hold_req = 1'b0;

	bqe_step_if   step_ch();
	bqe_result_if result_ch();

	bayesian_quote_engine_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step_ch),
		.result    (result_ch)
	);

	bqe_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.step           (step_ch),
		.result         (result_ch),
		.quotes_pending (quotes_pending),
		.quote_errors   (quote_errors)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((step_ch.valid && step_ch.ready) || (result_ch.valid && result_ch.ready)
				|| cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("bayesian_quote_engine_top: mismatch");
		$finish;
	end

	// result side: random ready, one long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				result_ch.ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end
			result_ch.ready <= calm || ($urandom_range(99) >= 21);
		end
	end

	// called and returns at a falling edge; valid stays up for back-to-back requests
	task automatic send_step(input logic [MODE_W-1:0] mode, input logic refresh);
		while (!calm && $urandom_range(99) < 21) begin
			step_ch.valid <= 1'b0;
			@(negedge clk);
		end
		step_ch.valid          <= 1'b1;
		step_ch.mode           <= mode;
		step_ch.refresh_quotes <= refresh;
		@(posedge clk);
		while (!step_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic quiesce();
		step_ch.valid <= 1'b0;
		@(negedge clk);
		while (quotes_pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PRICE_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [PRICE_W-1:0] share, vhigh, vlow, gain, mean,
			lo, hi);
		write_reg(REG_INFORMED_SHARE, share);
		write_reg(REG_VALUE_HIGH, vhigh);
		write_reg(REG_VALUE_LOW, vlow);
		write_reg(REG_REVERSION_GAIN, gain);
		write_reg(REG_LONG_RUN_BELIEF, mean);
		write_reg(REG_BELIEF_FLOOR, lo);
		write_reg(REG_BELIEF_CEILING, hi);
		cfg_we <= 1'b0;
	endtask

	// 16-bit registers ignore the top byte; put noise there
	function automatic logic [PRICE_W-1:0] with_junk(input logic [FRAC_W-1:0] v);
		return {(PRICE_W - FRAC_W)'($urandom), v};
	endfunction

	task automatic pick_setting(input int kind);
		logic [FRAC_W-1:0]  lo;
		logic [FRAC_W-1:0]  hi;
		logic [FRAC_W-1:0]  gain;
		logic [PRICE_W-1:0] vh;
		logic [PRICE_W-1:0] vl;
		case (kind)
			0: program_regs(PRICE_W'(RST_INFORMED_SHARE), RST_VALUE_HIGH, RST_VALUE_LOW,
				PRICE_W'(RST_REVERSION_GAIN), PRICE_W'(RST_LONG_RUN_BELIEF),
				PRICE_W'(RST_BELIEF_FLOOR), PRICE_W'(RST_BELIEF_CEILING));
			1: program_regs('1, '1, '1, '1, '1, '1, '1);
			2: program_regs('0, '0, '0, '0, '0, '0, '0);
			default: begin
				if ($urandom_range(3) == 0) begin
					lo = FRAC_W'($urandom_range(65535));
					hi = FRAC_W'($urandom_range(65535));
				end else begin
					lo = FRAC_W'($urandom_range(30000));
					hi = FRAC_W'($urandom_range(65535, 35000));
				end
				gain = ($urandom_range(3) == 0) ? FRAC_W'($urandom_range(65535))
					: FRAC_W'($urandom_range(3000));
				if ($urandom_range(1) == 0) begin
					vh = PRICE_W'($urandom_range(20000));
					vl = PRICE_W'($urandom_range(20000));
				end else begin
					vh = PRICE_W'($urandom);
					vl = PRICE_W'($urandom);
				end
				program_regs(with_junk(FRAC_W'($urandom_range(65535))), vh, vl,
					with_junk(gain), with_junk(FRAC_W'($urandom_range(65535))),
					with_junk(lo), with_junk(hi));
			end
		endcase
	endtask

	// trades come in bursts with a drifting buy/sell bias to push belief to its bounds
	task automatic run_random(input int count, input bit with_hold);
		int                buy_pct;
		int                r;
		logic [MODE_W-1:0] mode;
		buy_pct = 50;
		for (int i = 0; i < count; i++) begin
			if (i % 16 == 0) begin
				buy_pct = $urandom_range(100);
			end
			if (with_hold && i == 40) begin
				rx_hold_req = 1'b1;
			end
			r = $urandom_range(99);
			if (r < 10) begin
				mode = MODE_NONE;
			end else if (r < 15) begin
				mode = MODE_UNUSED;
			end else begin
				mode = ($urandom_range(99) < buy_pct) ? MODE_BUY : MODE_SELL;
			end
			send_step(mode, $urandom_range(2) == 0);
		end
	endtask

	initial begin
		logic [MODE_W-1:0] mode_list [4];
		mode_list = '{MODE_NONE, MODE_BUY, MODE_SELL, MODE_UNUSED};

		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = '0;
		cfg_data               = '0;
		step_ch.valid          = 1'b0;
		step_ch.mode           = MODE_NONE;
		step_ch.refresh_quotes = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// every mode with and without refresh at reset settings
		foreach (mode_list[k]) begin
			send_step(mode_list[k], 1'b0);
			send_step(mode_list[k], 1'b1);
		end

		// full informed share: first buy saturates the belief; held quotes survive the write
		quiesce();
		program_regs('1, '0, '1, '0, '1, '0, '1);
		send_step(MODE_NONE, 1'b0);
		send_step(MODE_BUY, 1'b0);
		send_step(MODE_BUY, 1'b0);
		send_step(MODE_NONE, 1'b1);
		send_step(MODE_SELL, 1'b0);
		send_step(MODE_SELL, 1'b0);
		send_step(MODE_SELL, 1'b0);
		send_step(MODE_UNUSED, 1'b1);

		// floor above ceiling, full-strength reversion to zero
		quiesce();
		program_regs('0, '1, '0, '1, '0, 24'd50000, 24'd10000);
		send_step(MODE_SELL, 1'b0);
		send_step(MODE_BUY, 1'b0);
		send_step(MODE_NONE, 1'b0);
		send_step(MODE_NONE, 1'b1);
		send_step(MODE_BUY, 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			quiesce();
			pick_setting(ph);
			calm = (ph == 3);
			run_random(PHASE_ITEMS, ph == 5);
		end
		calm = 1'b0;

		quiesce();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (quote_errors == 0 && quotes_pending == 0) begin
			$display("bayesian_quote_engine_top: match");
		end else begin
			$display("bayesian_quote_engine_top: mismatch");
		end
		$finish;
	end

endmodule
